// ===== hw/rtl/tmcw_pkg.sv =====
`timescale 1ns / 1ps

package tmcw_pkg;

   localparam int SCREEN_COLS_DEF = 80;
   localparam int SCREEN_ROWS_DEF = 25;

   localparam int CHAR_W     = 8;
   localparam int CELL_W     = 2 * CHAR_W;
   localparam int REQ_W      = 2;
   localparam int RD_ROW_W   = 5;
   localparam int RD_COL_W   = 7;
   localparam int OUT_COL_W  = 7;
   localparam int OUT_ROW_W  = 5;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
   localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'd15;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL,
      ST_BLANK,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic copy;
      logic fill;
      logic fill_space;
      logic respond;
   } dp_cmd_type;

   typedef struct packed {
      logic scroll_needed;
      logic copy_end;
      logic fill_end;
   } dp_status_type;

endpackage

// ===== hw/rtl/tmcw_ram.sv =====
`timescale 1ns / 1ps

module tmcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/tmcw_ctrl.sv =====
`timescale 1ns / 1ps

module tmcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_type,
   input  tmcw_pkg::dp_status_type status,
   output tmcw_pkg::dp_cmd_type    cmd,
   output logic                    busy
);

   import tmcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.fill_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_PUT: begin
                     state_in = status.scroll_needed ? ST_SCROLL : ST_RESP;
                  end
                  REQ_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            if (status.copy_end) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK, ST_CLEAR: begin
            if (status.fill_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         ST_SCROLL: begin
            cmd.copy = 1'b1;
         end
         ST_INIT, ST_BLANK: begin
            cmd.fill = 1'b1;
         end
         ST_CLEAR: begin
            cmd.fill       = 1'b1;
            cmd.fill_space = 1'b1;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/tmcw_datapath.sv =====
`timescale 1ns / 1ps

module tmcw_datapath #(
   parameter int SCREEN_COLS = tmcw_pkg::SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = tmcw_pkg::SCREEN_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tmcw_pkg::dp_cmd_type               cmd,
   output tmcw_pkg::dp_status_type            status,
   input  logic [tmcw_pkg::REQ_W-1:0]         req_type,
   input  logic [tmcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tmcw_pkg::RD_ROW_W-1:0]      req_read_row,
   input  logic [tmcw_pkg::RD_COL_W-1:0]      req_read_col,
   input  logic                               csr_we,
   input  logic [tmcw_pkg::CHAR_W-1:0]        csr_text_color,
   output logic                               rsp_strobe,
   output logic [tmcw_pkg::CHAR_W-1:0]        rsp_cell_char,
   output logic [tmcw_pkg::CHAR_W-1:0]        rsp_cell_attr,
   output logic [tmcw_pkg::OUT_COL_W-1:0]     rsp_cursor_col_out,
   output logic [tmcw_pkg::OUT_ROW_W-1:0]     rsp_cursor_row_out
);

   import tmcw_pkg::*;

   localparam int TOTAL  = SCREEN_ROWS * SCREEN_COLS;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int COL_W  = $clog2(SCREEN_COLS);
   localparam int ROW_W  = $clog2(SCREEN_ROWS);

   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TOTAL - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);

   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [CHAR_W-1:0]    color_ff, color_in;
   logic [REQ_W-1:0]     type_ff, type_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [CHAR_W-1:0]    rsp_attr_ff, rsp_attr_in;
   logic [OUT_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff, rsp_row_in;

   logic [COL_W-1:0]  put_col;
   logic [ROW_W-1:0]  put_row;
   logic              put_we;
   logic [COL_W-1:0]  put_wcol;
   logic [ROW_W-1:0]  put_wrow;
   logic [CELL_W-1:0] put_data;
   logic              put_scroll;
   logic [ADDR_W-1:0] put_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_ok;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   // Cursor movement and cell write for a put request, from the current cursor.
   always_comb begin
      put_col    = col_ff;
      put_row    = row_ff;
      put_we     = 1'b0;
      put_wcol   = col_ff;
      put_wrow   = row_ff;
      put_data   = {color_ff, req_char_code};
      put_scroll = 1'b0;
      if (req_char_code == CH_NEWLINE) begin
         put_col = '0;
         if (row_ff == ROW_LAST) begin
            put_scroll = 1'b1;
         end else begin
            put_row = row_ff + 1'b1;
         end
      end else if (req_char_code == CH_BACKSPACE) begin
         put_data = '0;
         if (col_ff == '0 && row_ff == '0) begin
            put_we = 1'b0;
         end else if (col_ff == '0) begin
            put_we   = 1'b1;
            put_col  = COL_LAST;
            put_row  = row_ff - 1'b1;
            put_wcol = COL_LAST;
            put_wrow = row_ff - 1'b1;
         end else begin
            put_we   = 1'b1;
            put_col  = col_ff - 1'b1;
            put_wcol = col_ff - 1'b1;
         end
      end else begin
         put_we = 1'b1;
         if (col_ff == COL_LAST) begin
            put_col = '0;
            if (row_ff == ROW_LAST) begin
               put_scroll = 1'b1;
            end else begin
               put_row = row_ff + 1'b1;
            end
         end else begin
            put_col = col_ff + 1'b1;
         end
      end
   end

   assign put_addr = ADDR_W'(put_wrow) * COLS_A + ADDR_W'(put_wcol);
   assign rd_addr  = ADDR_W'(req_read_row) * COLS_A + ADDR_W'(req_read_col);
   assign rd_ok    = (32'(req_read_row) < 32'(SCREEN_ROWS)) &&
                     (32'(req_read_col) < 32'(SCREEN_COLS));

   assign status.scroll_needed = put_scroll;
   assign status.copy_end      = (ptr_ff == COPY_LAST);
   assign status.fill_end      = (ptr_ff == ADDR_LAST);

   // A scroll copies each cell from one row below, one cell a cycle: the read of
   // the source issued in one cycle lands in the destination in the next.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = '0;
      ram_raddr = ptr_ff + COLS_A;
      if (cmd.accept) begin
         ram_raddr = rd_addr;
         if (req_type == REQ_PUT) begin
            ram_we    = put_we;
            ram_waddr = put_addr;
            ram_wdata = put_data;
         end
      end else if (cmd.copy) begin
         ram_we    = (ptr_ff != '0);
         ram_waddr = ptr_ff - 1'b1;
         ram_wdata = ram_rdata;
      end else if (cmd.fill) begin
         ram_we    = 1'b1;
         ram_wdata = cmd.fill_space ? {{CHAR_W{1'b0}}, CH_SPACE} : '0;
      end
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      color_in     = csr_we ? csr_text_color : color_ff;
      type_in      = type_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = cmd.respond;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (cmd.accept) begin
         type_in  = req_type;
         rd_ok_in = rd_ok;
         if (req_type == REQ_PUT) begin
            col_in = put_col;
            row_in = put_row;
         end else if (req_type == REQ_CLEAR) begin
            col_in = '0;
            row_in = '0;
         end
      end
      if (cmd.copy && !status.copy_end) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.fill) begin
         ptr_in = status.fill_end ? '0 : ptr_ff + 1'b1;
      end
      if (cmd.respond) begin
         if (type_ff == REQ_READ && rd_ok_ff) begin
            rsp_char_in = ram_rdata[CHAR_W-1:0];
            rsp_attr_in = ram_rdata[CELL_W-1:CHAR_W];
         end else begin
            rsp_char_in = '0;
            rsp_attr_in = '0;
         end
         rsp_col_in = OUT_COL_W'(col_ff);
         rsp_row_in = OUT_ROW_W'(row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= ROW_W'(1);
         ptr_ff       <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   tmcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(TOTAL)
   ) u_cells (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_attr      = rsp_attr_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cursor_row_out = rsp_row_ff;

endmodule

// ===== hw/rtl/text_mode_console_writer.sv =====
// A put that does not scroll, a read or an unused request: busy is high in the RESP state
// only, and the result strobe is registered from that state. No new request is taken until
// busy is low again. A put that scrolls copies the screen up through the single write port
// of the cell RAM. Clear writes every cell once. The receiver cannot stall.
// After synchronous reset the cell RAM is zeroed one cell a cycle; busy stays high until
// every cell is zeroed. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module text_mode_console_writer #(
   parameter int SCREEN_COLS = tmcw_pkg::SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = tmcw_pkg::SCREEN_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tmcw_pkg::REQ_W-1:0]         req_type,
   input  logic [tmcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tmcw_pkg::RD_ROW_W-1:0]      req_read_row,
   input  logic [tmcw_pkg::RD_COL_W-1:0]      req_read_col,
   input  logic                               csr_we,
   input  logic [tmcw_pkg::CHAR_W-1:0]        csr_text_color,
   output logic                               rsp_strobe,
   output logic [tmcw_pkg::CHAR_W-1:0]        rsp_cell_char,
   output logic [tmcw_pkg::CHAR_W-1:0]        rsp_cell_attr,
   output logic [tmcw_pkg::OUT_COL_W-1:0]     rsp_cursor_col_out,
   output logic [tmcw_pkg::OUT_ROW_W-1:0]     rsp_cursor_row_out
);

   import tmcw_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tmcw_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_type(req_type),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   tmcw_datapath #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_col      (req_read_col),
      .csr_we            (csr_we),
      .csr_text_color    (csr_text_color),
      .rsp_strobe        (rsp_strobe),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_cursor_col_out(rsp_cursor_col_out),
      .rsp_cursor_row_out(rsp_cursor_row_out)
   );

endmodule
